// ===== rtl/sdm_pkg.sv =====
// Shared types and constants of the grid-synchronised SPWM modulator.
`default_nettype none
package sdm_pkg;

    localparam int DIV_W = 40;
    localparam int DVS_W = 17;
    localparam int IN_W  = 72;
    localparam int OUT_W = 72;

    localparam logic [30:0] FF_GAIN = 31'd1159043113;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        KIND_STEP    = 2'd0,
        KIND_NEUTRAL = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_SPARE   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [16:0] rate;
        logic [15:0] limit;
        logic [19:0] start;
        logic [19:0] maxc;
        logic [15:0] target;
        logic [15:0] ind;
        logic [1:0]  bsign;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_SYNC, OP_STEP, OP_RAMP, OP_M2, OP_M3, OP_M4,
        OP_ADD, OP_M5, OP_DROP, OP_NUM, OP_APPLY, OP_FA, OP_FB, OP_PUSH
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  take_div;
        logic  mod_ok;
        logic  div_done;
        logic  out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/sdm_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module sdm_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [sdm_pkg::DIV_W-1:0]  i_dividend,
    input  wire logic [sdm_pkg::DVS_W-1:0]  i_divisor,
    output logic                            o_done,
    output logic [sdm_pkg::DIV_W-1:0]       o_quotient
);
    localparam int CW = $clog2(sdm_pkg::DIV_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic [sdm_pkg::DIV_W-1:0]   r_q;
    logic [sdm_pkg::DVS_W-1:0]   r_rem;
    logic [sdm_pkg::DVS_W-1:0]   r_d;
    logic [sdm_pkg::DVS_W:0]     w_trial;
    logic [sdm_pkg::DVS_W:0]     w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_q[sdm_pkg::DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign w_diff  = w_trial - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(sdm_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[sdm_pkg::DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[sdm_pkg::DVS_W-1:0] : w_trial[sdm_pkg::DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule
`default_nettype wire

// ===== rtl/sdm_dpath.sv =====
// Datapath: phase tracking, current ramp, feedforward, modulation and compares.
`default_nettype none
module sdm_dpath #(
    parameter int HALF_PERIOD     = 17000,
    parameter int PHASE_BITS      = 16,
    parameter int COS_TABLE_DEPTH = 256
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire sdm_pkg::t_cfg              i_cfg,
    input  wire sdm_pkg::t_cmd              i_cmd,
    output sdm_pkg::t_sts                   o_sts,
    input  wire logic [sdm_pkg::IN_W-1:0]   i_in_data,
    input  wire logic [1:0]                 i_in_user,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [sdm_pkg::OUT_W-1:0]       o_out_data
);
    localparam int QB = PHASE_BITS - 2;
    localparam int IW = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PW = QB + 13;
    localparam logic [15:0] HP = 16'(HALF_PERIOD);

    typedef logic [15:0] t_tab [0:COS_TABLE_DEPTH];

    function automatic t_tab f_build();
        t_tab              tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sum;
        longint unsigned   c;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x    = (sdm_pkg::HALF_PI_Q30 * 64'(k) + 64'(COS_TABLE_DEPTH / 2))
                   / 64'(COS_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            sum  = longint'(term);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1) sum = sum - longint'(term);
                else sum = sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            c = (64'(sum) + 64'd16384) >> 15;
            if (c > 64'd32768) c = 64'd32768;
            tab[k] = c[15:0];
        end
        return tab;
    endfunction

    localparam t_tab COS_TAB = f_build();

    // captured beat
    sdm_pkg::t_kind  r_kind;
    logic            r_in_mv;
    logic            r_in_lk;
    logic [15:0]     r_in_cross;
    logic [15:0]     r_in_freq;
    logic [15:0]     r_in_lv;
    logic [15:0]     r_in_bus;

    // state
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    logic [19:0]           r_cur;
    logic [15:0]           r_last;
    logic                  r_sync;
    logic                  r_health;
    logic [15:0]           r_held_lv;
    logic [15:0]           r_held_bus;
    logic [15:0]           r_held_freq;
    logic                  r_held_valid;
    logic signed [16:0]    r_mod;

    // working registers
    logic [63:0] r_prod;
    logic [19:0] r_n_hi;
    logic [31:0] r_tlo;
    logic [35:0] r_a;
    logic [15:0] r_ac;
    logic        r_cneg;
    logic [20:0] r_dm;
    logic        r_nneg;
    logic [15:0] r_cmp_a;
    logic        r_out_valid;
    logic [sdm_pkg::OUT_W-1:0] r_out;

    logic [31:0]              w_ma;
    logic [31:0]              w_mb;
    logic                     w_mul_en;
    logic                     w_take_div;
    logic                     w_div_start;
    logic [sdm_pkg::DIV_W-1:0] w_dvd;
    logic [sdm_pkg::DVS_W-1:0] w_dvs;
    logic                     w_div_done;
    logic [sdm_pkg::DIV_W-1:0] w_quot;
    logic [1:0]               w_quad;
    logic [PW-1:0]            w_scaled;
    logic [IW-1:0]            w_idx;
    logic [IW-1:0]            w_tab_idx;
    logic [20:0]              w_cur_inc;
    logic [51:0]              w_hi;
    logic [63:0]              w_dm_sum;
    logic signed [22:0]       w_vac;
    logic signed [22:0]       w_drop;
    logic signed [22:0]       w_num;
    logic [21:0]              w_mag;
    logic [16:0]              w_bdiv;
    logic [16:0]              w_lim;
    logic [16:0]              w_qc;
    logic signed [16:0]       w_qs;
    logic signed [16:0]       w_m;
    logic [17:0]              w_fa;
    logic [17:0]              w_fb;
    logic [63:0]              w_round;

    assign w_take_div = r_in_mv && r_in_lk && (r_in_cross != r_last);

    // cosine lookup, lower table point
    assign w_quad    = r_phase[PHASE_BITS-1:PHASE_BITS-2];
    assign w_scaled  = PW'(r_phase[QB-1:0]) * PW'(COS_TABLE_DEPTH);
    assign w_idx     = IW'(w_scaled >> QB);
    assign w_tab_idx = w_quad[0] ? IW'(COS_TABLE_DEPTH) - w_idx : w_idx;

    assign w_cur_inc = {1'b0, r_cur} + 21'd5;
    assign w_hi      = r_prod[51:0] + {20'b0, r_tlo};
    assign w_dm_sum  = r_prod + {12'b0, 20'(r_a[35:32]) * 20'(r_ac), 32'b0} + 64'd1073741824;

    assign w_vac  = 23'($signed(r_held_lv));
    assign w_drop = r_cneg ? -$signed({2'b0, r_dm}) : $signed({2'b0, r_dm});
    assign w_num  = w_vac - w_drop;
    assign w_mag  = w_num[22] ? 22'(-w_num) : 22'(w_num);
    assign w_bdiv = (r_held_bus < 16'd512) ? 17'd512 : {1'b0, r_held_bus};

    assign w_lim = (i_cfg.limit > 16'd32768) ? 17'd32768 : {1'b0, i_cfg.limit};
    assign w_qc  = (w_quot > sdm_pkg::DIV_W'(w_lim)) ? w_lim : w_quot[16:0];
    assign w_qs  = $signed(w_qc);
    always_comb begin
        w_m = r_nneg ? -w_qs : w_qs;
        if (i_cfg.bsign == 2'd0) w_m = '0;
        else if (i_cfg.bsign[1]) w_m = -w_m;
    end

    assign w_fa    = 18'd32768 - 18'($signed(r_mod));
    assign w_fb    = 18'd32768 + 18'($signed(r_mod));
    assign w_round = r_prod + 64'd16384;

    // shared divider
    assign w_div_start = (i_cmd.op == sdm_pkg::OP_NUM) ||
                         (i_cmd.op == sdm_pkg::OP_SYNC && r_kind == sdm_pkg::KIND_STEP &&
                          w_take_div);
    always_comb begin
        if (i_cmd.op == sdm_pkg::OP_NUM) begin
            w_dvd = sdm_pkg::DIV_W'({w_mag, 15'b0}) + sdm_pkg::DIV_W'(w_bdiv >> 1);
            w_dvs = w_bdiv;
        end else begin
            w_dvd = sdm_pkg::DIV_W'({r_in_freq, {(PHASE_BITS-8){1'b0}}});
            w_dvs = (i_cfg.rate == '0) ? 17'd1 : i_cfg.rate;
        end
    end

    sdm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // shared multiplier operand select
    always_comb begin
        w_mul_en = 1'b1;
        w_ma     = '0;
        w_mb     = '0;
        case (i_cmd.op)
            sdm_pkg::OP_RAMP: begin
                w_ma = 32'(r_held_freq);
                w_mb = 32'(i_cfg.ind);
            end
            sdm_pkg::OP_M2: begin
                w_ma = r_prod[31:0];
                w_mb = 32'(r_cur);
            end
            sdm_pkg::OP_M3: begin
                w_ma = r_prod[31:0];
                w_mb = 32'(sdm_pkg::FF_GAIN);
            end
            sdm_pkg::OP_M4: begin
                w_ma = 32'(r_n_hi);
                w_mb = 32'(sdm_pkg::FF_GAIN);
            end
            sdm_pkg::OP_M5: begin
                w_ma = r_a[31:0];
                w_mb = 32'(r_ac);
            end
            sdm_pkg::OP_FA: begin
                w_ma = 32'(HP);
                w_mb = 32'(w_fa[16:0]);
            end
            sdm_pkg::OP_FB: begin
                w_ma = 32'(HP);
                w_mb = 32'(w_fb[16:0]);
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mul_en) r_prod <= {32'b0, w_ma} * {32'b0, w_mb};
        if (i_cmd.op == sdm_pkg::OP_LOAD) begin
            r_kind     <= sdm_pkg::t_kind'(i_in_user);
            r_in_mv    <= i_in_data[0];
            r_in_lk    <= i_in_data[1];
            r_in_cross <= i_in_data[17:2];
            r_in_freq  <= i_in_data[33:18];
            r_in_lv    <= i_in_data[49:34];
            r_in_bus   <= i_in_data[65:50];
        end
        case (i_cmd.op)
            sdm_pkg::OP_RAMP: begin
                r_ac   <= COS_TAB[w_tab_idx];
                r_cneg <= w_quad[1] ^ w_quad[0];
            end
            sdm_pkg::OP_M3:   r_n_hi  <= r_prod[51:32];
            sdm_pkg::OP_M4:   r_tlo   <= r_prod[63:32];
            sdm_pkg::OP_ADD:  r_a     <= w_hi[51:16];
            sdm_pkg::OP_DROP: r_dm    <= w_dm_sum[51:31];
            sdm_pkg::OP_NUM:  r_nneg  <= w_num[22];
            sdm_pkg::OP_FB:   r_cmp_a <= w_round[30:15];
            sdm_pkg::OP_PUSH: r_out   <= {1'b0, r_health, r_sync, r_cur, r_mod,
                                          w_round[30:15], r_cmp_a};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_step       <= '0;
            r_cur        <= '0;
            r_last       <= '0;
            r_sync       <= 1'b0;
            r_health     <= 1'b1;
            r_held_lv    <= '0;
            r_held_bus   <= '0;
            r_held_freq  <= '0;
            r_held_valid <= 1'b0;
            r_mod        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == sdm_pkg::OP_PUSH) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            case (i_cmd.op)
                sdm_pkg::OP_SYNC: begin
                    case (r_kind)
                        sdm_pkg::KIND_STEP: begin
                            if (!r_in_mv) begin
                                r_health <= 1'b0;
                            end else begin
                                r_held_valid <= 1'b1;
                                r_held_freq  <= r_in_freq;
                                r_held_lv    <= r_in_lv;
                                r_held_bus   <= r_in_bus;
                                if (!w_take_div) begin
                                    if (r_sync) r_phase <= r_phase + r_step;
                                    r_health <= 1'b1;
                                end
                            end
                        end
                        sdm_pkg::KIND_RESTART: begin
                            r_phase  <= '0;
                            r_step   <= '0;
                            r_cur    <= '0;
                            r_last   <= '0;
                            r_sync   <= 1'b0;
                            r_health <= 1'b1;
                            r_mod    <= '0;
                        end
                        default: r_mod <= '0;
                    endcase
                end
                sdm_pkg::OP_STEP: begin
                    r_phase  <= '0;
                    r_step   <= (w_quot > sdm_pkg::DIV_W'({PHASE_BITS{1'b1}})) ?
                                '1 : w_quot[PHASE_BITS-1:0];
                    r_last   <= r_in_cross;
                    r_sync   <= 1'b1;
                    r_health <= 1'b1;
                end
                sdm_pkg::OP_RAMP: begin
                    if (!(r_sync && r_held_valid)) begin
                        r_health <= 1'b0;
                    end else if (r_cur < i_cfg.start) begin
                        r_cur <= i_cfg.start;
                    end else if (r_held_bus < i_cfg.target && r_cur < i_cfg.maxc) begin
                        r_cur <= (w_cur_inc > {1'b0, i_cfg.maxc}) ? i_cfg.maxc :
                                 w_cur_inc[19:0];
                    end
                end
                sdm_pkg::OP_APPLY: r_mod <= w_m;
                default: ;
            endcase
        end
    end

    assign o_sts.kind     = r_kind;
    assign o_sts.take_div = w_take_div;
    assign o_sts.mod_ok   = r_sync && r_held_valid;
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
endmodule
`default_nettype wire

// ===== rtl/sdm_ctrl.sv =====
// Controller: sequences one beat through the datapath.
`default_nettype none
module sdm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire sdm_pkg::t_sts  i_sts,
    output sdm_pkg::t_cmd       o_cmd
);
    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_SYNC = 15'b000000000000010,
        ST_STEP = 15'b000000000000100,
        ST_RAMP = 15'b000000000001000,
        ST_M2   = 15'b000000000010000,
        ST_M3   = 15'b000000000100000,
        ST_M4   = 15'b000000001000000,
        ST_ADD  = 15'b000000010000000,
        ST_M5   = 15'b000000100000000,
        ST_DROP = 15'b000001000000000,
        ST_NUM  = 15'b000010000000000,
        ST_QDIV = 15'b000100000000000,
        ST_FA   = 15'b001000000000000,
        ST_FB   = 15'b010000000000000,
        ST_PUSH = 15'b100000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = sdm_pkg::OP_NONE;
        case (r_state)
            ST_IDLE: if (i_in_valid) begin
                o_cmd.op = sdm_pkg::OP_LOAD;
                n_state  = ST_SYNC;
            end
            ST_SYNC: begin
                o_cmd.op = sdm_pkg::OP_SYNC;
                if (i_sts.kind != sdm_pkg::KIND_STEP) n_state = ST_FA;
                else if (i_sts.take_div) n_state = ST_STEP;
                else n_state = ST_RAMP;
            end
            ST_STEP: if (i_sts.div_done) begin
                o_cmd.op = sdm_pkg::OP_STEP;
                n_state  = ST_RAMP;
            end
            ST_RAMP: begin
                o_cmd.op = sdm_pkg::OP_RAMP;
                n_state  = i_sts.mod_ok ? ST_M2 : ST_FA;
            end
            ST_M2: begin
                o_cmd.op = sdm_pkg::OP_M2;
                n_state  = ST_M3;
            end
            ST_M3: begin
                o_cmd.op = sdm_pkg::OP_M3;
                n_state  = ST_M4;
            end
            ST_M4: begin
                o_cmd.op = sdm_pkg::OP_M4;
                n_state  = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.op = sdm_pkg::OP_ADD;
                n_state  = ST_M5;
            end
            ST_M5: begin
                o_cmd.op = sdm_pkg::OP_M5;
                n_state  = ST_DROP;
            end
            ST_DROP: begin
                o_cmd.op = sdm_pkg::OP_DROP;
                n_state  = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.op = sdm_pkg::OP_NUM;
                n_state  = ST_QDIV;
            end
            ST_QDIV: if (i_sts.div_done) begin
                o_cmd.op = sdm_pkg::OP_APPLY;
                n_state  = ST_FA;
            end
            ST_FA: begin
                o_cmd.op = sdm_pkg::OP_FA;
                n_state  = ST_FB;
            end
            ST_FB: begin
                o_cmd.op = sdm_pkg::OP_FB;
                n_state  = ST_PUSH;
            end
            ST_PUSH: if (i_sts.out_free) begin
                o_cmd.op = sdm_pkg::OP_PUSH;
                n_state  = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    assign o_in_ready = (r_state == ST_IDLE);

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_STEP || r_state == ST_QDIV))
        else $error("divider finished outside a wait state");

    a_num_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NUM) |=> (r_state == ST_QDIV))
        else $error("modulation division not awaited");

    a_short_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SYNC && i_sts.kind != sdm_pkg::KIND_STEP) |=> (r_state == ST_FA))
        else $error("neutral or restart beat took the long path");
endmodule
`default_nettype wire

// ===== rtl/grid_synced_spwm_modulator.sv =====
// Top level: register port, controller and datapath of the SPWM modulator.
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata, tuser = kind
//  m_axis    out  m_axis_tvalid/tready      tdata
//  apb       in   psel/penable/pwrite       paddr, pwdata, prdata
//
// A control step that modulates waits on the shared divider for its quotient, and a
// step that also resyncs waits on it once more for the new phase step. Neutral and
// restart beats and steps that cannot modulate skip the modulation division.
// Synchronous active-low reset puts the registers at their defaults, health set.
// A result waits in the output register; the next beat is taken meanwhile and its
// result is held back until that register drains.
`default_nettype none
module grid_synced_spwm_modulator #(
    parameter int HALF_PERIOD     = 17000,
    parameter int PHASE_BITS      = 16,
    parameter int COS_TABLE_DEPTH = 256
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // meas_valid, line_locked, cross_count, line_freq, line_volts, bus_volts
    input  wire logic [sdm_pkg::IN_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic [1:0]                s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // cmp_a, cmp_b, modulation, current_cmd, synced, healthy
    output logic [sdm_pkg::OUT_W-1:0]      m_axis_tdata,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [4:0]                paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    localparam logic [2:0] REG_RATE   = 3'd0;
    localparam logic [2:0] REG_LIMIT  = 3'd1;
    localparam logic [2:0] REG_START  = 3'd2;
    localparam logic [2:0] REG_MAXC   = 3'd3;
    localparam logic [2:0] REG_TARGET = 3'd4;
    localparam logic [2:0] REG_IND    = 3'd5;
    localparam logic [2:0] REG_BSIGN  = 3'd6;

    sdm_pkg::t_cfg r_cfg;
    sdm_pkg::t_cmd w_cmd;
    sdm_pkg::t_sts w_sts;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rate   <= 17'd10000;
            r_cfg.limit  <= 16'd29491;
            r_cfg.start  <= 20'd15000;
            r_cfg.maxc   <= 20'd100000;
            r_cfg.target <= 16'd2304;
            r_cfg.ind    <= 16'd1000;
            r_cfg.bsign  <= 2'd1;
        end else if (w_wr) begin
            case (paddr[4:2])
                REG_RATE:   r_cfg.rate   <= pwdata[16:0];
                REG_LIMIT:  r_cfg.limit  <= pwdata[15:0];
                REG_START:  r_cfg.start  <= pwdata[19:0];
                REG_MAXC:   r_cfg.maxc   <= pwdata[19:0];
                REG_TARGET: r_cfg.target <= pwdata[15:0];
                REG_IND:    r_cfg.ind    <= pwdata[15:0];
                REG_BSIGN:  r_cfg.bsign  <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_RATE:   prdata = 32'(r_cfg.rate);
            REG_LIMIT:  prdata = 32'(r_cfg.limit);
            REG_START:  prdata = 32'(r_cfg.start);
            REG_MAXC:   prdata = 32'(r_cfg.maxc);
            REG_TARGET: prdata = 32'(r_cfg.target);
            REG_IND:    prdata = 32'(r_cfg.ind);
            REG_BSIGN:  prdata = 32'(r_cfg.bsign);
            default:    prdata = '0;
        endcase
    end

    sdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sdm_dpath #(
        .HALF_PERIOD     (HALF_PERIOD),
        .PHASE_BITS      (PHASE_BITS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );
endmodule
`default_nettype wire

// ===== tb/tb_grid_synced_spwm_modulator.sv =====
// Testbench of the grid-synchronised SPWM modulator: directed and random beats checked against a predictor.
`default_nettype none

typedef struct {
    bit [1:0]  kind;
    bit        mv;
    bit        lk;
    bit [15:0] cc;
    bit [15:0] lf;
    bit [15:0] lv;
    bit [15:0] bv;
} t_meas_beat;

typedef struct {
    bit [15:0] ca;
    bit [15:0] cb;
    bit [16:0] md;
    bit [19:0] cur;
    bit        sy;
    bit        hl;
} t_mod_result;

class modulator_scoreboard;
    int unsigned rate, lim, start_i, max_i, target, ind, bsign;
    int unsigned phase, step, cur, last_cross, sync, health;
    int unsigned hv, hb, hf, hvalid;
    int          amod;
    int          cos_q15[257];
    t_mod_result due_q[$];
    int          errors;

    function new();
        longint unsigned x, x2, term;
        longint          sum;
        longint unsigned c;
        rate = 10000; lim = 29491; start_i = 15000; max_i = 100000;
        target = 2304; ind = 1000; bsign = 1;
        phase = 0; step = 0; cur = 0; last_cross = 0; sync = 0; health = 1;
        hv = 0; hb = 0; hf = 0; hvalid = 0; amod = 0; errors = 0;
        for (int k = 0; k <= 256; k++) begin
            x = (sdm_pkg::HALF_PI_Q30 * k + 128) / 256;
            x2 = (x * x) >> 30;
            term = 64'd1 << 30;
            sum = longint'(term);
            for (int n = 1; n <= 10; n++) begin
                term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
                if (n & 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            c = (longint'(sum) + 16384) >> 15;
            if (c > 32768) c = 32768;
            cos_q15[k] = int'(c);
        end
    endfunction

    function void set_reg(int idx, int unsigned val);
        case (idx)
            0: rate = val & 32'h1FFFF;
            1: lim = val & 32'hFFFF;
            2: start_i = val & 32'hFFFFF;
            3: max_i = val & 32'hFFFFF;
            4: target = val & 32'hFFFF;
            5: ind = val & 32'hFFFF;
            6: bsign = val & 32'h3;
            default: ;
        endcase
    endfunction

    function int cos_of(int unsigned ph);
        int unsigned idx;
        idx = (ph & 32'h3FFF) >> 6;
        case ((ph >> 14) & 3)
            0: return cos_q15[idx];
            1: return -cos_q15[256 - idx];
            2: return -cos_q15[idx];
            default: return cos_q15[256 - idx];
        endcase
    endfunction

    function void modulate();
        int c;
        longint unsigned ac, n, hi, a, dm, mag, dv, q, lm, ff;
        longint vac, drop, num, m;
        if (!sync || !hvalid) begin
            health = 0;
            return;
        end
        if (cur < start_i) cur = start_i;
        else if (hb < target && cur < max_i) begin
            cur += 5;
            if (cur > max_i) cur = max_i;
        end
        c = cos_of(phase);
        ac = (c < 0) ? -c : c;
        ff = sdm_pkg::FF_GAIN;
        n = longint'(hf) * ind * cur;
        hi = (n >> 32) * ff + (((n & 64'hFFFFFFFF) * ff) >> 32);
        a = hi >> 16;
        dm = (a * ac + (64'd1 << 30)) >> 31;
        drop = (c < 0) ? -longint'(dm) : longint'(dm);
        vac = longint'(hv & 32'h7FFF) - longint'(hv & 32'h8000);
        num = vac - drop;
        dv = (hb < 512) ? 512 : hb;
        mag = (num < 0) ? -num : num;
        q = (mag * 32768 + dv / 2) / dv;
        lm = (lim > 32768) ? 32768 : lim;
        if (q > lm) q = lm;
        m = (num < 0) ? -longint'(q) : longint'(q);
        if (bsign == 0) m = 0;
        else if (bsign >= 2) m = -m;
        amod = int'(m);
    endfunction

    function void note_beat(t_meas_beat b);
        t_mod_result r;
        longint unsigned rt, st;
        if (b.kind == sdm_pkg::KIND_STEP) begin
            if (!b.mv) health = 0;
            else begin
                hvalid = 1; hf = b.lf; hv = b.lv; hb = b.bv;
                if (b.lk && b.cc != last_cross) begin
                    rt = (rate != 0) ? rate : 1;
                    st = (longint'(hf) << 16) / (256 * rt);
                    if (st > 65535) st = 65535;
                    last_cross = b.cc; phase = 0; step = 32'(st); sync = 1;
                end else if (sync) begin
                    phase = (phase + step) & 32'hFFFF;
                end
                health = 1;
            end
            modulate();
        end else if (b.kind == sdm_pkg::KIND_RESTART) begin
            phase = 0; step = 0; cur = 0; last_cross = 0;
            sync = 0; health = 1; amod = 0;
        end else begin
            amod = 0;
        end
        r.ca = 16'((17000 * longint'(32768 - amod) + 16384) >> 15);
        r.cb = 16'((17000 * longint'(32768 + amod) + 16384) >> 15);
        r.md = 17'(amod);
        r.cur = 20'(cur);
        r.sy = sync[0];
        r.hl = health[0];
        due_q.push_back(r);
    endfunction

    function void check_result(logic [71:0] d);
        t_mod_result e;
        if (due_q.size() == 0) begin
            $error("result beat with nothing expected: %h", d);
            errors++;
            return;
        end
        e = due_q.pop_front();
        if (d[15:0] !== e.ca) begin
            $error("cmp_a exp %0d got %0d", e.ca, d[15:0]); errors++;
        end
        if (d[31:16] !== e.cb) begin
            $error("cmp_b exp %0d got %0d", e.cb, d[31:16]); errors++;
        end
        if (d[48:32] !== e.md) begin
            $error("modulation exp %h got %h", e.md, d[48:32]); errors++;
        end
        if (d[68:49] !== e.cur) begin
            $error("current_cmd exp %0d got %0d", e.cur, d[68:49]); errors++;
        end
        if (d[69] !== e.sy) begin
            $error("synced exp %0d got %0d", e.sy, d[69]); errors++;
        end
        if (d[70] !== e.hl) begin
            $error("healthy exp %0d got %0d", e.hl, d[70]); errors++;
        end
    endfunction
endclass

module tb_grid_synced_spwm_modulator;
    localparam int LIMIT = 1500000;
    localparam int PHASE_ITEMS = 230;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;   // meas_valid, line_locked, cross_count, line_freq,
                                      // line_volts, bus_volts
    logic [1:0]  s_axis_tuser = '0;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // cmp_a, cmp_b, modulation, current_cmd,
                                      // synced, healthy
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    modulator_scoreboard sb = new();
    bit          idle_on = 1'b1;
    int          stall_left = 0;
    int          cycles = 0;
    int          sent = 0;
    bit [15:0]   seq_cross = 16'd1;

    grid_synced_spwm_modulator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(int idx, int unsigned val);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 5'(idx * 4); pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic send(t_meas_beat b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= b.kind;
        s_axis_tdata <= {6'b0, b.bv, b.lv, b.lf, b.cc, b.lk, b.mv};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_beat(b);
        sent++;
    endtask

    function automatic t_meas_beat mk(bit [1:0] k, bit mv, bit lk, bit [15:0] cc,
                                      bit [15:0] lf, bit [15:0] lv, bit [15:0] bv);
        t_meas_beat b;
        b.kind = k; b.mv = mv; b.lk = lk; b.cc = cc; b.lf = lf; b.lv = lv; b.bv = bv;
        return b;
    endfunction

    task automatic noise_beat();
        send(mk(2'($urandom), 1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                16'($urandom), 16'($urandom)));
    endtask

    // one stretch of mostly locked line cycles, crossings every 3 to 40 steps
    task automatic line_run(int n);
        int          per;
        bit [15:0]   fq, bv;
        bit [1:0]    k;
        per = $urandom_range(3, 40);
        fq = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(11000, 16000));
        for (int i = 0; i < n; i++) begin
            if (i % per == 0) seq_cross++;
            k = sdm_pkg::KIND_STEP;
            if ($urandom_range(0, 40) == 0) k = sdm_pkg::KIND_NEUTRAL;
            else if ($urandom_range(0, 60) == 0) k = sdm_pkg::KIND_RESTART;
            bv = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 3000));
            send(mk(k, $urandom_range(0, 15) != 0, $urandom_range(0, 20) != 0,
                    seq_cross, fq, 16'($urandom), bv));
        end
    endtask

    task automatic set_phase_regs(int p);
        int unsigned v[7];
        if (p == 1) v = '{1000, 0, 0, 0, 0, 0, 0};
        else if (p == 2) v = '{100000, 32768, 1000000, 1000000, 65535, 65535, 3};
        else if (p == 3) v = '{0, 65535, 1048575, 1048575, 65535, 65535, 2};
        else if (p == 4) v = '{131071, 32768, 500, 600, 40000, 3000, 1};
        else begin
            v[0] = $urandom_range(1000, 100000);
            v[1] = $urandom_range(0, 32768);
            v[2] = $urandom_range(0, 200000);
            v[3] = $urandom_range(0, 1000000);
            v[4] = $urandom;
            v[5] = $urandom;
            v[6] = $urandom_range(0, 3);
        end
        for (int i = 0; i < 7; i++) write_reg(i, v[i]);
    endtask

    initial begin
        int cnt;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        send(mk(sdm_pkg::KIND_RESTART, 1, 1, 0, 12800, 0, 0));
        send(mk(sdm_pkg::KIND_STEP, 0, 1, 3, 12800, 1000, 9000));
        send(mk(sdm_pkg::KIND_STEP, 1, 0, 3, 12800, 1000, 9000));
        send(mk(sdm_pkg::KIND_STEP, 1, 1, 5, 12800, 2000, 9000));
        for (int i = 0; i < 4; i++)
            send(mk(sdm_pkg::KIND_STEP, 1, 1, 5, 12800, 16'(i * 3000), 2000));
        send(mk(sdm_pkg::KIND_NEUTRAL, 1, 1, 5, 0, 0, 0));
        send(mk(sdm_pkg::KIND_SPARE, 1, 1, 5, 0, 0, 0));
        send(mk(sdm_pkg::KIND_STEP, 1, 1, 6, 16'hFFFF, 16'h8000, 16'h0000));
        send(mk(sdm_pkg::KIND_STEP, 1, 1, 6, 16'hFFFF, 16'h7FFF, 16'hFFFF));
        send(mk(sdm_pkg::KIND_STEP, 1, 1, 0, 16'h0000, 16'h8000, 16'h01FF));
        send(mk(sdm_pkg::KIND_STEP, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send(mk(sdm_pkg::KIND_STEP, 1, 1, 16'hFFFF, 13000, 16'h7FFF, 16'h0200));
        send(mk(sdm_pkg::KIND_RESTART, 0, 0, 0, 0, 0, 0));
        send(mk(sdm_pkg::KIND_STEP, 1, 1, 0, 12800, 500, 9000));
        send(mk(sdm_pkg::KIND_STEP, 1, 1, 1, 12800, 500, 9000));
        drain();

        for (int p = 0; p < 8; p++) begin
            if (p > 0) set_phase_regs(p);
            idle_on = (p != 3 && p != 7);
            cnt = 0;
            while (cnt < PHASE_ITEMS) begin
                if (p == 4 && cnt > 100 && cnt < 106) begin
                    s_axis_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.due_q.size() != 0) @(posedge i_clk);
                end
                if ($urandom_range(0, 4) == 0) begin
                    noise_beat();
                    cnt++;
                end else begin
                    int n;
                    n = $urandom_range(10, 50);
                    if (n > PHASE_ITEMS - cnt) n = PHASE_ITEMS - cnt;
                    line_run(n);
                    cnt += n;
                end
            end
            drain();
        end

        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/sdm_pkg.sv
rtl/sdm_div.sv
rtl/sdm_dpath.sv
rtl/sdm_ctrl.sv
rtl/grid_synced_spwm_modulator.sv
tb/tb_grid_synced_spwm_modulator.sv
